>>> hdl/prr_pkg.sv
// ----------------------------------------------------------------------------
// prr_pkg: shared types and constants of the rational resampler
// Field widths, register index codes and the control bundle that the
// sequencer hands to the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package prr_pkg;

    // payload widths
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = SAMPLE_W - 1;
    localparam int COEF_IDX_W = 10;
    localparam int FACTOR_W   = 7;
    localparam int TAPS_W     = 11;
    localparam int POS_W      = 13;
    localparam int FACTOR_MAX = 64;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_FACTOR   = 2'd0,
        CFG_DOWN_FACTOR = 2'd1,
        CFG_TAP_COUNT   = 2'd2
    } cfg_reg_t;

    // sequencer to mac control
    typedef struct packed {
        logic clear;
        logic issue;
    } mac_ctrl_t;

endpackage

>>> hdl/prr_ram.sv
// ----------------------------------------------------------------------------
// prr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module prr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/prr_mac.sv
// ----------------------------------------------------------------------------
// prr_mac: shared multiply-accumulate unit
// Registers the RAM read, multiplies one tap per cycle, accumulates and
// rounds/saturates the sum back to Q1.15.
// ----------------------------------------------------------------------------
module prr_mac import prr_pkg::*; #(
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] coef,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       busy,
    output logic signed [SAMPLE_W-1:0] result
);

    localparam int PROD_W = 2 * SAMPLE_W;
    localparam int ACC_W  = PROD_W + $clog2(HISTORY_DEPTH) + 1;
    localparam logic signed [ACC_W:0] Q_MAX = (ACC_W+1)'(2 ** (SAMPLE_W - 1) - 1);
    localparam logic signed [ACC_W:0] Q_MIN = -(ACC_W+1)'(2 ** (SAMPLE_W - 1));
    localparam logic signed [ACC_W:0] HALF  = (ACC_W+1)'(2 ** (FRAC_BITS - 1));

    logic                     data_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W:0]    rnd_sum;
    logic signed [ACC_W:0]    rnd_q;

    // tap pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            data_vld_reg <= ctrl.issue;
            prod_vld_reg <= data_vld_reg;
        end
    end

    // product register and accumulator
    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sample;
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    assign busy = data_vld_reg | prod_vld_reg;

    // round half up, floor shift, saturate
    assign rnd_sum = {acc_reg[ACC_W-1], acc_reg} + HALF;
    assign rnd_q   = rnd_sum >>> FRAC_BITS;

    always_comb
    begin
        priority if (rnd_q > Q_MAX)
        begin
            result = Q_MAX[SAMPLE_W-1:0];
        end
        else if (rnd_q < Q_MIN)
        begin
            result = Q_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            result = rnd_q[SAMPLE_W-1:0];
        end
    end

    // clearing only happens with the pipeline empty
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |-> !busy)
        else $error("mac cleared while taps in flight");

    // an issued tap passes the data and product valid flags before the accumulator
    a_tap_flow: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.issue |=> ##1 prod_vld_reg)
        else $error("issued tap lost in mac pipeline");

endmodule

>>> hdl/prr_ctrl.sv
// ----------------------------------------------------------------------------
// prr_ctrl: resampler sequencer
// Takes input transactions, keeps the history ring pointer, the phase
// counter and the tap walk, and holds the output register.
// ----------------------------------------------------------------------------
module prr_ctrl import prr_pkg::*; #(
    parameter int MAX_COEFS     = 1024,
    parameter int HISTORY_DEPTH = 64,
    localparam int CAW = $clog2(MAX_COEFS),
    localparam int HAW = $clog2(HISTORY_DEPTH)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [COEF_IDX_W-1:0]      coef_index,
    input  logic signed [SAMPLE_W-1:0] coef_value,
    // configuration
    input  logic [FACTOR_W-1:0]        up_factor,
    input  logic [FACTOR_W-1:0]        down_factor,
    input  logic [TAPS_W-1:0]          tap_count,
    // coefficient store
    output logic                       coef_we,
    output logic [CAW-1:0]             coef_waddr,
    output logic [SAMPLE_W-1:0]        coef_wdata,
    output logic [CAW-1:0]             coef_raddr,
    // history ring
    output logic                       ring_we,
    output logic [HAW-1:0]             ring_waddr,
    output logic [SAMPLE_W-1:0]        ring_wdata,
    output logic [HAW-1:0]             ring_raddr,
    input  logic [SAMPLE_W-1:0]        ring_rdata,
    // mac
    output mac_ctrl_t                  mac_ctrl,
    output logic signed [SAMPLE_W-1:0] mac_sample,
    input  logic                       mac_busy,
    input  logic signed [SAMPLE_W-1:0] mac_result,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last
);

    localparam int TW  = (TAPS_W > $clog2(MAX_COEFS + 1)) ? TAPS_W : $clog2(MAX_COEFS + 1);
    localparam int KW  = TW + 1;
    localparam int BW  = $clog2(HISTORY_DEPTH + 1);
    localparam int CIW = ((COEF_IDX_W > CAW) ? COEF_IDX_W : CAW) + 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_TAPS  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [HAW-1:0]             wp_reg, wp_next;
    logic [HISTORY_DEPTH-1:0]   hvalid_reg, hvalid_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic                       last_reg, last_next;
    logic [FACTOR_W-1:0]        u_reg, u_next;
    logic [FACTOR_W-1:0]        d_reg, d_next;
    logic [TW-1:0]              taps_reg, taps_next;
    logic [HAW-1:0]             newest_reg, newest_next;
    logic [KW-1:0]              k_reg, k_next;
    logic [BW-1:0]              back_reg, back_next;
    logic [HAW-1:0]             slot_reg, slot_next;
    logic                       hv_q_reg;

    logic                       accept;
    logic                       coef_ok;
    logic [FACTOR_W-1:0]        u_cl;
    logic [FACTOR_W-1:0]        d_cl;
    logic [TW-1:0]              taps_cl;
    logic                       tap_go;
    logic [POS_W-1:0]           pos_step;

    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        r = f;
        if (f == '0)
        begin
            r = FACTOR_W'(1);
        end
        else if (f > FACTOR_W'(FACTOR_MAX))
        begin
            r = FACTOR_W'(FACTOR_MAX);
        end
        return r;
    endfunction

    // input side
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign coef_ok  = (CIW'(coef_index) < CIW'(MAX_COEFS));

    assign coef_we    = accept && func && coef_ok;
    assign coef_waddr = CAW'(coef_index);
    assign coef_wdata = coef_value;
    assign ring_we    = accept && !func;
    assign ring_waddr = wp_reg;
    assign ring_wdata = sample_in;

    // effective settings
    assign u_cl    = clamp_factor(up_factor);
    assign d_cl    = clamp_factor(down_factor);
    assign taps_cl = (TW'(tap_count) > TW'(MAX_COEFS)) ? TW'(MAX_COEFS) : TW'(tap_count);

    // tap walk
    assign tap_go     = (k_reg < KW'(taps_reg)) && (back_reg < BW'(HISTORY_DEPTH));
    assign coef_raddr = CAW'(k_reg);
    assign ring_raddr = slot_reg;
    assign pos_step   = pos_reg + POS_W'(d_reg);

    // never-written history entries read as zero
    assign mac_sample = hv_q_reg ? signed'(ring_rdata) : '0;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        wp_next         = wp_reg;
        hvalid_next     = hvalid_reg;
        out_valid_next  = out_valid_reg && out_stall;
        sample_out_next = sample_out_reg;
        last_next       = last_reg;
        u_next          = u_reg;
        d_next          = d_reg;
        taps_next       = taps_reg;
        newest_next     = newest_reg;
        k_next          = k_reg;
        back_next       = back_reg;
        slot_next       = slot_reg;
        mac_ctrl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !func)
                begin
                    hvalid_next[wp_reg] = 1'b1;
                    u_next      = u_cl;
                    d_next      = d_cl;
                    taps_next   = taps_cl;
                    newest_next = wp_reg;
                    wp_next     = (wp_reg == HAW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + HAW'(1);
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (pos_reg < POS_W'(u_reg))
                begin
                    k_next         = KW'(pos_reg);
                    back_next      = '0;
                    slot_next      = newest_reg;
                    mac_ctrl.clear = 1'b1;
                    state_next     = S_TAPS;
                end
                else
                begin
                    pos_next   = pos_reg - POS_W'(u_reg);
                    state_next = S_IDLE;
                end
            end
            S_TAPS:
            begin
                if (tap_go)
                begin
                    mac_ctrl.issue = 1'b1;
                    k_next    = k_reg + KW'(u_reg);
                    back_next = back_reg + BW'(1);
                    slot_next = (slot_reg == '0) ? HAW'(HISTORY_DEPTH - 1) : slot_reg - HAW'(1);
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    sample_out_next = mac_result;
                    last_next       = (pos_step >= POS_W'(u_reg));
                    pos_next        = pos_step;
                    state_next      = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            wp_reg        <= '0;
            hvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            wp_reg        <= wp_next;
            hvalid_reg    <= hvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sample_out_reg <= sample_out_next;
        last_reg       <= last_next;
        u_reg          <= u_next;
        d_reg          <= d_next;
        taps_reg       <= taps_next;
        newest_reg     <= newest_next;
        k_reg          <= k_next;
        back_reg       <= back_next;
        slot_reg       <= slot_next;
        hv_q_reg       <= hvalid_reg[slot_reg];
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign last       = last_reg;

    // new transactions only start with the mac empty
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !mac_busy)
        else $error("input accepted while mac busy");

    // result taken only after the last tap is accumulated
    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !mac_busy)
        else $error("emit before mac drained");

    // the walked phase stays below the up factor
    a_walk_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAPS) |-> (pos_reg < POS_W'(u_reg)))
        else $error("phase out of range during tap walk");

    // the walk never reaches past the history depth
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAPS) |-> (back_reg <= BW'(HISTORY_DEPTH)))
        else $error("tap walk beyond history");

endmodule

>>> hdl/polyphase_rational_resampler.sv
// ----------------------------------------------------------------------------
// polyphase_rational_resampler: rational U/D resampler, polyphase FIR
// Coefficient transactions fill the coefficient RAM, sample transactions
// enter the history ring and produce zero or more filtered outputs.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   in       | in_valid / in_stall | func, sample_in, coef_index, coef_value
//   out      | out_valid/out_stall | sample_out, last
//   config   | cfg_we              | cfg_index, cfg_data
//
// A coefficient write leaves the sequencer idle. A sample stalls the input
// until the sequencer is back in idle, and each of its outputs at phase p
// walks min(ceil((taps in use - p)/U), depth) taps.
// The single multiply-accumulate unit takes one tap per cycle through the
// coefficient RAM read port, so the tap count per phase sets the rate.
// Reset clears the history ring through per-entry valid bits, no sweep.
// A stalled output holds the sequencer until the result register frees up.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler import prr_pkg::*; #(
    parameter int MAX_COEFS     = 1024,
    parameter int HISTORY_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic [COEF_IDX_W-1:0]      coef_index,
    input  logic signed [SAMPLE_W-1:0] coef_value,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       last
);

    localparam int CAW = $clog2(MAX_COEFS);
    localparam int HAW = $clog2(HISTORY_DEPTH);

    logic [FACTOR_W-1:0]        up_factor_reg;
    logic [FACTOR_W-1:0]        down_factor_reg;
    logic [TAPS_W-1:0]          tap_count_reg;

    logic                       coef_we;
    logic [CAW-1:0]             coef_waddr;
    logic [SAMPLE_W-1:0]        coef_wdata;
    logic [CAW-1:0]             coef_raddr;
    logic [SAMPLE_W-1:0]        coef_rdata;
    logic                       ring_we;
    logic [HAW-1:0]             ring_waddr;
    logic [SAMPLE_W-1:0]        ring_wdata;
    logic [HAW-1:0]             ring_raddr;
    logic [SAMPLE_W-1:0]        ring_rdata;
    mac_ctrl_t                  mac_ctrl;
    logic signed [SAMPLE_W-1:0] mac_sample;
    logic                       mac_busy;
    logic signed [SAMPLE_W-1:0] mac_result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg   <= FACTOR_W'(1);
            down_factor_reg <= FACTOR_W'(1);
            tap_count_reg   <= TAPS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UP_FACTOR:   up_factor_reg   <= cfg_data[FACTOR_W-1:0];
                CFG_DOWN_FACTOR: down_factor_reg <= cfg_data[FACTOR_W-1:0];
                CFG_TAP_COUNT:   tap_count_reg   <= cfg_data[TAPS_W-1:0];
                default:         ;
            endcase
        end
    end

    // coefficient store
    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_COEFS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (coef_wdata),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // history ring
    prr_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // sequencer
    prr_ctrl #(
        .MAX_COEFS     (MAX_COEFS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .sample_in   (sample_in),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .up_factor   (up_factor_reg),
        .down_factor (down_factor_reg),
        .tap_count   (tap_count_reg),
        .coef_we     (coef_we),
        .coef_waddr  (coef_waddr),
        .coef_wdata  (coef_wdata),
        .coef_raddr  (coef_raddr),
        .ring_we     (ring_we),
        .ring_waddr  (ring_waddr),
        .ring_wdata  (ring_wdata),
        .ring_raddr  (ring_raddr),
        .ring_rdata  (ring_rdata),
        .mac_ctrl    (mac_ctrl),
        .mac_sample  (mac_sample),
        .mac_busy    (mac_busy),
        .mac_result  (mac_result),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .sample_out  (sample_out),
        .last        (last)
    );

    // shared multiply-accumulate
    prr_mac #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (signed'(coef_rdata)),
        .sample (mac_sample),
        .busy   (mac_busy),
        .result (mac_result)
    );

endmodule

>>> sim/tb_polyphase_rational_resampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyphase_rational_resampler: self-checking bench for the U/D resampler
// A behavioral polyphase filter predicts every output from the accepted
// transactions. Outputs are compared in order on sample_out and last. A short
// directed table covers rounding, saturation and the odd register settings.
// Random traffic follows, with random gaps and output stalls, over a list of
// U/D/tap settings.
// ----------------------------------------------------------------------------
module tb_polyphase_rational_resampler import prr_pkg::*; ();

    localparam int     COEF_DEPTH    = 1024;
    localparam int     HIST_DEPTH    = 64;
    localparam logic   FUNC_SAMPLE   = 1'b0;
    localparam logic   FUNC_COEF     = 1'b1;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     ITEM_TARGET   = 360;
    localparam int     TAP_CAP       = 128;
    localparam int     PHASE_ITEMS   = 12;
    localparam longint CYCLE_LIMIT   = 20000000;

    typedef struct {
        logic                       fn;
        logic signed [SAMPLE_W-1:0] smp;
        logic [COEF_IDX_W-1:0]      addr;
        logic signed [SAMPLE_W-1:0] cval;
    } xact_t;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } out_word_t;

    typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        cfg_reg_t                   sel;
        logic [CFG_DATA_W-1:0]      word;
        xact_t                      xact;
        bit                         pinned;
        logic signed [SAMPLE_W-1:0] want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [COEF_IDX_W-1:0]      coef_index;
    logic signed [SAMPLE_W-1:0] coef_value;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last;

    // filter state mirror
    logic [FACTOR_W-1:0]        up_reg;
    logic [FACTOR_W-1:0]        down_reg;
    logic [TAPS_W-1:0]          taps_reg;
    logic signed [SAMPLE_W-1:0] coef_mem [COEF_DEPTH];
    bit                         coef_loaded [COEF_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
    int unsigned                next_slot;
    int unsigned                phase_pos;

    out_word_t                  pending_outputs [$];
    out_word_t                  seen;
    stim_row_t                  directed_rows [$];

    int     errors = 0;
    int     samples_sent;
    int     coefs_sent;
    int     outputs_checked = 0;
    int     settings_used;
    longint cycle_count = 0;
    bit     quiet;
    int     rnd_up;
    int     rnd_down;
    int     rnd_taps;

    polyphase_rational_resampler i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .last       (last)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // zero or over-range factors fold into 1..64
    function automatic int unsigned eff_factor(logic [FACTOR_W-1:0] f);
        if (f == 0)
            return 1;
        if (f > FACTOR_W'(FACTOR_MAX))
            return FACTOR_MAX;
        return int'(f);
    endfunction

    function automatic int unsigned eff_taps();
        return (taps_reg > TAPS_W'(COEF_DEPTH)) ? COEF_DEPTH : int'(taps_reg);
    endfunction

    // q2.30 accumulator back to q1.15, floor after the half-lsb offset
    function automatic logic signed [SAMPLE_W-1:0] round_saturate(longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> FRAC_BITS;
        if (q > 32767)
            q = 32767;
        else if (q < -32768)
            q = -32768;
        return q[SAMPLE_W-1:0];
    endfunction

    // one output of phase p, newest sample at slot newest
    function automatic logic signed [SAMPLE_W-1:0] phase_output(int unsigned p,
            int unsigned u, int unsigned taps, int unsigned newest);
        longint      acc;
        int unsigned k;
        int unsigned back;
        int unsigned slot;
        acc  = 0;
        k    = p;
        back = 0;
        while (k < taps && back < HIST_DEPTH)
        begin
            slot = (newest + HIST_DEPTH - back) % HIST_DEPTH;
            acc += longint'(coef_mem[k]) * longint'(hist_mem[slot]);
            k += u;
            back++;
        end
        return round_saturate(acc);
    endfunction

    // advance the mirror by one accepted transaction, queue its outputs
    task automatic resample_step(xact_t x, bit pinned, logic signed [SAMPLE_W-1:0] want);
        int unsigned u;
        int unsigned d;
        int unsigned taps;
        int unsigned newest;
        int unsigned produced;
        out_word_t   w;
        if (x.fn == FUNC_COEF)
        begin
            coef_mem[x.addr]    = x.cval;
            coef_loaded[x.addr] = 1'b1;
            coefs_sent++;
        end
        else
        begin
            samples_sent++;
            u        = eff_factor(up_reg);
            d        = eff_factor(down_reg);
            taps     = eff_taps();
            newest   = next_slot;
            produced = 0;
            hist_mem[newest] = x.smp;
            // phase counter stands in for n*D/U; a counter left above U emits nothing
            while (phase_pos < u && produced < 64)
            begin
                w.value = phase_output(phase_pos, u, taps, newest);
                w.last  = 1'b0;
                pending_outputs.push_back(w);
                produced++;
                phase_pos += d;
            end
            if (produced > 0)
            begin
                pending_outputs[pending_outputs.size()-1].last = 1'b1;
                if (pinned)
                    pending_outputs[pending_outputs.size()-1].value = want;
            end
            phase_pos = (phase_pos >= u) ? phase_pos - u : 0;
            phase_pos &= 32'h1FFF;
            next_slot = (newest + 1) % HIST_DEPTH;
        end
    endtask

    // present one transaction, optionally after random gaps
    task automatic send_xact(xact_t x, bit pinned, logic signed [SAMPLE_W-1:0] want);
        while (!quiet && $urandom_range(0, 99) < 15)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        func       <= x.fn;
        sample_in  <= x.smp;
        coef_index <= x.addr;
        coef_value <= x.cval;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        resample_step(x, pinned, want);
    endtask

    // stop sending and wait for every queued output plus trailing work
    task automatic go_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write on an idle block; factor writes carry junk above bit 6
    task automatic write_register(cfg_reg_t sel, logic [CFG_DATA_W-1:0] word);
        go_idle();
        if (sel != CFG_TAP_COUNT)
            word[CFG_DATA_W-1:FACTOR_W] = (CFG_DATA_W-FACTOR_W)'($urandom_range(0, 15));
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= word;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (sel)
            CFG_UP_FACTOR:   up_reg   = word[FACTOR_W-1:0];
            CFG_DOWN_FACTOR: down_reg = word[FACTOR_W-1:0];
            default:         taps_reg = word[TAPS_W-1:0];
        endcase
    endtask

    // every coefficient the current setting can reach gets written first
    task automatic load_missing_coefs();
        int unsigned reach;
        int unsigned bound;
        xact_t       x;
        reach = eff_factor(up_reg) * HIST_DEPTH;
        bound = (eff_taps() < reach) ? eff_taps() : reach;
        for (int i = 0; i < bound; i++)
        begin
            if (!coef_loaded[i])
            begin
                x.fn   = FUNC_COEF;
                x.addr = COEF_IDX_W'(i);
                x.cval = SAMPLE_W'($urandom);
                x.smp  = SAMPLE_W'($urandom);
                send_xact(x, 1'b0, '0);
            end
        end
    endtask

    // random traffic under one U/D/tap setting, sized by its cost per sample
    task automatic run_phase(int u, int d, int taps);
        int unsigned walk;
        int unsigned outs;
        int unsigned cost;
        int unsigned budget;
        int unsigned done;
        xact_t       x;
        write_register(CFG_UP_FACTOR, CFG_DATA_W'(u));
        write_register(CFG_DOWN_FACTOR, CFG_DATA_W'(d));
        write_register(CFG_TAP_COUNT, CFG_DATA_W'(taps));
        load_missing_coefs();
        settings_used++;
        walk = (eff_taps() + eff_factor(up_reg) - 1) / eff_factor(up_reg);
        if (walk > HIST_DEPTH)
            walk = HIST_DEPTH;
        outs   = (eff_factor(up_reg) + eff_factor(down_reg) - 1) / eff_factor(down_reg);
        cost   = outs * (walk + 5) + 2;
        budget = 24000 / cost;
        if (budget > PHASE_ITEMS)
            budget = PHASE_ITEMS;
        if (budget < 4)
            budget = 4;
        done = 0;
        while (done < budget)
        begin
            x.fn   = ($urandom_range(0, 99) < 12) ? FUNC_COEF : FUNC_SAMPLE;
            x.addr = COEF_IDX_W'($urandom_range(0, COEF_DEPTH - 1));
            x.cval = SAMPLE_W'($urandom);
            case ($urandom_range(0, 9))
                0:       x.smp = 16'sh7FFF;
                1:       x.smp = 16'sh8000;
                2:       x.smp = 16'($urandom_range(0, 255)) - 16'd128;
                default: x.smp = SAMPLE_W'($urandom);
            endcase
            if (x.fn == FUNC_SAMPLE)
                done++;
            send_xact(x, 1'b0, '0);
        end
    endtask

    // directed table entries
    function automatic void add_cfg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] word);
        stim_row_t r;
        r.kind   = ROW_CFG;
        r.sel    = sel;
        r.word   = word;
        r.pinned = 1'b0;
        r.want   = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_coef(logic [COEF_IDX_W-1:0] addr,
            logic signed [SAMPLE_W-1:0] val);
        stim_row_t r;
        r.kind      = ROW_ITEM;
        r.xact.fn   = FUNC_COEF;
        r.xact.addr = addr;
        r.xact.cval = val;
        r.xact.smp  = SAMPLE_W'($urandom);
        r.pinned    = 1'b0;
        r.want      = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_sample(logic signed [SAMPLE_W-1:0] val, bit pinned,
            logic signed [SAMPLE_W-1:0] want);
        stim_row_t r;
        r.kind      = ROW_ITEM;
        r.xact.fn   = FUNC_SAMPLE;
        r.xact.smp  = val;
        r.xact.addr = COEF_IDX_W'($urandom);
        r.xact.cval = SAMPLE_W'($urandom);
        r.pinned    = pinned;
        r.want      = want;
        directed_rows.push_back(r);
    endfunction

    // receiver back-pressure
    always @(negedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < 15);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d outputs still expected", $time, pending_outputs.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outputs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output transaction: expected none, actual %0d last %0b",
                         $time, sample_out, last);
            end
            else
            begin
                seen = pending_outputs.pop_front();
                outputs_checked++;
                if (sample_out !== seen.value)
                begin
                    errors++;
                    $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                             $time, seen.value, sample_out);
                end
                if (last !== seen.last)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, seen.last, last);
                end
            end
        end
    end

    // stimulus
    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        func       = FUNC_SAMPLE;
        sample_in  = '0;
        coef_index = '0;
        coef_value = '0;
        quiet      = 1'b0;
        samples_sent    = 0;
        coefs_sent      = 0;
        settings_used   = 0;
        up_reg    = 7'd1;
        down_reg  = 7'd1;
        taps_reg  = 11'd1;
        next_slot = 0;
        phase_pos = 0;
        for (int i = 0; i < HIST_DEPTH; i++)
            hist_mem[i] = '0;
        for (int i = 0; i < COEF_DEPTH; i++)
            coef_loaded[i] = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting U=D=1, one tap: rounding and saturation extremes
        add_coef(10'd0, 16'sh7FFF);
        add_sample(16'sh7FFF, 1'b1, 16'sh7FFE);
        add_sample(16'sh8000, 1'b1, 16'sh8001);
        add_coef(10'd0, 16'sh8000);
        add_sample(16'sh8000, 1'b1, 16'sh7FFF);
        add_sample(16'sh7FFF, 1'b1, 16'sh8001);
        add_coef(10'd0, 16'sh0001);
        add_sample(16'sh4000, 1'b1, 16'sh0001);
        add_sample(16'sh3FFF, 1'b1, 16'sh0000);
        add_sample(16'shC000, 1'b1, 16'sh0000);
        add_sample(16'shBFFF, 1'b1, 16'shFFFF);
        // empty sum
        add_cfg(CFG_TAP_COUNT, 11'd0);
        add_sample(16'sh3039, 1'b1, 16'sh0000);
        add_coef(10'd1023, 16'shFFFF);
        // zero factors act as one
        add_cfg(CFG_UP_FACTOR, 11'd0);
        add_cfg(CFG_DOWN_FACTOR, 11'd0);
        add_cfg(CFG_TAP_COUNT, 11'd1);
        add_sample(16'sh8000, 1'b0, '0);
        // over-range factors clamp to 64
        add_cfg(CFG_UP_FACTOR, 11'd127);
        add_cfg(CFG_DOWN_FACTOR, 11'd127);
        add_cfg(CFG_TAP_COUNT, 11'd100);
        add_sample(16'sh1234, 1'b0, '0);
        add_sample(16'shEDCB, 1'b0, '0);
        // tap count above the store, taps reaching past the history
        add_cfg(CFG_UP_FACTOR, 11'd1);
        add_cfg(CFG_DOWN_FACTOR, 11'd1);
        add_cfg(CFG_TAP_COUNT, 11'd2047);
        add_sample(16'sh7FFF, 1'b0, '0);
        add_sample(16'sh8000, 1'b0, '0);
        // phase counter left above a smaller U after reconfiguration
        add_cfg(CFG_UP_FACTOR, 11'd8);
        add_cfg(CFG_DOWN_FACTOR, 11'd7);
        add_cfg(CFG_TAP_COUNT, 11'd40);
        add_sample(16'sh5A5A, 1'b0, '0);
        add_cfg(CFG_UP_FACTOR, 11'd2);
        add_sample(16'sh0101, 1'b0, '0);
        add_sample(16'shA5A5, 1'b0, '0);
        add_sample(16'sh7F00, 1'b0, '0);
        add_sample(16'sh80FF, 1'b0, '0);
        add_coef(10'd512, 16'sh2AAA);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                write_register(directed_rows[r].sel, directed_rows[r].word);
                load_missing_coefs();
            end
            else
                send_xact(directed_rows[r].xact, directed_rows[r].pinned, directed_rows[r].want);
        end

        // fixed settings, second and third without any gaps or stalls
        run_phase(1, 1, 1);
        quiet = 1'b1;
        run_phase(3, 2, 24);
        run_phase(2, 3, 16);
        quiet = 1'b0;
        run_phase(1, 64, 64);
        run_phase(64, 64, 128);
        run_phase(64, 1, 128);
        run_phase(5, 7, 40);
        run_phase(7, 5, 35);
        run_phase(1, 1, 2047);
        run_phase(0, 0, 0);
        run_phase(127, 127, 128);

        // random settings, mostly small factors
        while (samples_sent + coefs_sent < ITEM_TARGET)
        begin
            rnd_up   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            rnd_down = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            if ($urandom_range(0, 4) == 0)
                rnd_taps = $urandom_range(0, TAP_CAP);
            else
                rnd_taps = $urandom_range(0, (8 * rnd_up < TAP_CAP) ? 8 * rnd_up : TAP_CAP);
            run_phase(rnd_up, rnd_down, rnd_taps);
        end

        go_idle();
        $display("covered %0d sample and %0d coefficient transactions over %0d settings",
                 samples_sent, coefs_sent, settings_used);
        $display("checked %0d outputs, %0d mismatches", outputs_checked, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/prr_pkg.sv
hdl/prr_ram.sv
hdl/prr_mac.sv
hdl/prr_ctrl.sv
hdl/polyphase_rational_resampler.sv
sim/tb_polyphase_rational_resampler.sv
